[src/htld_pkg.sv]
// Shared constants and types for the heading turn lap detector.
// No dependencies.
package htld_pkg;
  localparam int RUN_LENGTH_DEF = 40;
  localparam int COUNT_BITS_DEF = 24;
  localparam int LAP_BITS_DEF   = 16;
  localparam int SUM_W          = 33;
  localparam int HEAD_W         = 9;
  localparam int TIME_W         = 31;
  localparam int DIST_W         = 24;
  localparam int SCORE_W        = 9;
  localparam int IMPR_W         = 7;
  localparam int POOL_W         = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_LENGTH = 1'b0,
    REG_PREV_AVG    = 1'b1
  } cfg_reg_t;

  // Request to the serial divider and its answer.
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  num;
    logic [SUM_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quo;
  } div_rsp_t;
endpackage

[src/htld_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on htld_pkg.
module htld_div
  import htld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r;
  logic [SUM_W:0]   rem_r;
  logic [SUM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W:0]   trial;

  assign trial = {rem_r[SUM_W-1:0], quo_r[SUM_W-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      if (!trial[SUM_W]) begin
        rem_r <= trial;
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[SUM_W-1:0], quo_r[SUM_W-1]};
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

[src/heading_turn_lap_detector.sv]
// Heading turn lap detector top level: sequencer, state and result register.
// Depends on htld_pkg and htld_div.
//
//   channel | direction | handshake     | payload
//   in_     | input     | valid / stall | heading_deg, lap_elapsed
//   out_    | output    | valid / stall | lap_done, lap_total, distance_m,
//           |           |               | score_average, improvement_pct
//   cfg_    | input     | valid / ready | index, data
//
// Each divider pass has a start state and a wait state that holds until
// the quotient is done. A sample runs the mean, filter and scaled mean
// passes, then the run check, lap update, distance and result beat states;
// a new sample beat is taken only back in idle, once the result is taken.
// A lap adds the numerator state, and a divider pass when the improvement
// ratio is divided. The first sample skips the mean pass. An output stall
// holds the result beat. Reset is synchronous and active low; it leaves the
// sample, working and distance registers uncleared. The lap time is reduced
// modulo 60 one bit per cycle while the divider passes run.
module heading_turn_lap_detector
  import htld_pkg::*;
#(
  parameter int RUN_LENGTH = RUN_LENGTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LAP_BITS   = LAP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [HEAD_W-1:0]     in_heading_deg,
  input  logic [TIME_W-1:0]     in_lap_elapsed,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_lap_done,
  output logic [LAP_BITS-1:0]   out_lap_total,
  output logic [DIST_W-1:0]     out_distance_m,
  output logic [SCORE_W-1:0]    out_score_average,
  output logic [IMPR_W-1:0]     out_improvement_pct,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int RUN_W = 6;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LAP_BITS-1:0]   LAP_MAX   = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_MEAN_W, S_FILT, S_FILT_W, S_SCALE, S_SCALE_W,
    S_RUN, S_LAP, S_NUM, S_IMP, S_IMP_W, S_DIST, S_OUT
  } state_t;

  state_t               state_r;
  logic [POOL_W-1:0]    pool_r;
  logic [SCORE_W-1:0]   prev_r;
  logic [HEAD_W-1:0]    filt_r;
  logic                 fseed_r, mseed_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [SUM_W-1:0]     sum_r;
  logic [RUN_W-1:0]     run_nn_r, run_ng_r;
  logic [LAP_BITS-1:0]  laps_r;
  logic [SCORE_W-1:0]   avg_r;
  logic [IMPR_W-1:0]    imp_r;
  logic [HEAD_W-1:0]    h_r;
  logic [5:0]           t_r;
  logic [SUM_W-1:0]     mean_r;
  logic [SUM_W-1:0]     scaled_r;
  logic                 fire_r;
  logic [SUM_W-1:0]     n_r;
  logic                 out_valid_r;
  logic [DIST_W-1:0]    dist_r;
  div_req_t             dreq;
  div_rsp_t             drsp;

  // Lap time modulo 60, reduced one bit per cycle from the top down.
  logic [TIME_W-1:0]    tsh_r;
  logic [6:0]           trem_r;
  logic [4:0]           tcnt_r;
  logic [6:0]           trem_sh;
  logic [6:0]           trem_nxt;

  assign trem_sh  = {trem_r[5:0], tsh_r[TIME_W-1]};
  assign trem_nxt = (trem_sh >= 7'd60) ? trem_sh - 7'd60 : trem_sh;

  htld_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [SUM_W:0]    sum_add;
  logic [9:0]        score;
  logic [SUM_W+8:0]  mul_p;
  logic [SUM_W+8:0]  den_p;
  logic [LAP_BITS+POOL_W-1:0] dist_full;
  logic [LAP_BITS-1:0] laps_new;
  logic [SCORE_W:0]    avg_sum;
  logic [SCORE_W-1:0]  avg_new;
  logic [17:0]         imp_pos;
  logic [17:0]         imp_neg;

  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(in_heading_deg);
  assign score   = (pool_r == POOL_W'(50)) ? ({2'b0, pool_r} + {4'b0, t_r[5:0]}) >> 1
                                           : {2'b0, pool_r} + {4'b0, t_r[5:0]};
  assign dist_full = laps_r * pool_r;

  // Lap count after this lap, and the running average that goes with it.
  assign laps_new = (laps_r != LAP_MAX) ? laps_r + 1'b1 : laps_r;
  assign avg_sum  = {1'b0, avg_r} + score;
  assign avg_new  = (laps_new == LAP_BITS'(1)) ? '0
                  : (laps_new == LAP_BITS'(2)) ? score[SCORE_W-1:0]
                  : avg_sum[SCORE_W:1];

  // Improvement numerator 199*P - 200*average, positive only when P wins.
  assign imp_pos = 18'(prev_r) * 18'd199;
  assign imp_neg = 18'(avg_r) * 18'd200;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  assign out_lap_done        = fire_r;
  assign out_lap_total       = laps_r;
  assign out_distance_m      = dist_r;
  assign out_score_average   = avg_r;
  assign out_improvement_pct = imp_r;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    mul_p      = '0;
    den_p      = '0;
    unique case (state_r)
      S_MEAN: begin
        dreq.start = 1'b1;
        dreq.num   = sum_r;
        dreq.den   = SUM_W'(count_r);
      end
      S_FILT: begin
        dreq.start = 1'b1;
        mul_p      = 42'(filt_r) * 42'd49 + 42'(h_r) + 42'd25;
        dreq.num   = mul_p[SUM_W-1:0];
        dreq.den   = SUM_W'(50);
      end
      S_SCALE: begin
        dreq.start = 1'b1;
        mul_p      = 42'(mean_r) * 42'd49;
        dreq.num   = mul_p[SUM_W-1:0];
        dreq.den   = SUM_W'(50);
      end
      S_IMP: begin
        dreq.start = 1'b1;
        dreq.num   = n_r;
        den_p      = 42'(prev_r) << 1;
        dreq.den   = den_p[SUM_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_r      <= '0;
      prev_r      <= '0;
      filt_r      <= '0;
      fseed_r     <= 1'b0;
      mseed_r     <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      run_nn_r    <= '0;
      run_ng_r    <= '0;
      laps_r      <= '0;
      avg_r       <= '0;
      imp_r       <= '0;
      out_valid_r <= 1'b0;
      fire_r      <= 1'b0;
      tcnt_r      <= '0;
    end else begin
      // The lap time is loaded only in idle, when this count has run out.
      if (tcnt_r != '0) begin
        trem_r <= trem_nxt;
        tsh_r  <= tsh_r << 1;
        tcnt_r <= tcnt_r - 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_POOL_LENGTH) pool_r <= cfg_data[POOL_W-1:0];
            else prev_r <= cfg_data;
          end
          if (in_valid) begin
            h_r    <= in_heading_deg;
            tsh_r  <= in_lap_elapsed;
            trem_r <= '0;
            tcnt_r <= 5'(TIME_W);
            if (count_r != COUNT_MAX) count_r <= count_r + 1'b1;
            if (!mseed_r) begin
              sum_r <= SUM_W'(in_heading_deg);
            end else begin
              sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
            state_r <= mseed_r ? S_MEAN : S_FILT;
            mean_r  <= SUM_W'(in_heading_deg);
            mseed_r <= 1'b1;
          end
        end
        S_MEAN: state_r <= S_MEAN_W;
        S_MEAN_W: begin
          if (drsp.done) begin
            mean_r  <= drsp.quo;
            state_r <= S_FILT;
          end
        end
        S_FILT: state_r <= S_FILT_W;
        S_FILT_W: begin
          if (drsp.done) begin
            filt_r  <= fseed_r ? drsp.quo[HEAD_W-1:0] : h_r;
            fseed_r <= 1'b1;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: state_r <= S_SCALE_W;
        S_SCALE_W: begin
          if (drsp.done) begin
            scaled_r <= drsp.quo;
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          if (scaled_r >= SUM_W'(filt_r)) begin
            run_ng_r <= '0;
            fire_r   <= (run_nn_r == RUN_W'(RUN_LENGTH - 1));
            if (run_nn_r < RUN_W'(RUN_LENGTH)) run_nn_r <= run_nn_r + 1'b1;
          end else begin
            run_nn_r <= '0;
            fire_r   <= (run_ng_r == RUN_W'(RUN_LENGTH - 1));
            if (run_ng_r < RUN_W'(RUN_LENGTH)) run_ng_r <= run_ng_r + 1'b1;
          end
          t_r     <= trem_r[5:0];
          state_r <= S_LAP;
        end
        S_LAP: begin
          if (fire_r) begin
            laps_r  <= laps_new;
            avg_r   <= avg_new;
            state_r <= S_NUM;
          end else begin
            state_r <= S_DIST;
          end
        end
        S_NUM: begin
          if (laps_r > LAP_BITS'(1) && prev_r != '0) begin
            if (imp_pos > imp_neg) begin
              n_r     <= SUM_W'(imp_pos - imp_neg);
              state_r <= S_IMP;
            end else begin
              imp_r   <= '0;
              state_r <= S_DIST;
            end
          end else begin
            state_r <= S_DIST;
          end
        end
        S_IMP: state_r <= S_IMP_W;
        S_IMP_W: begin
          if (drsp.done) begin
            imp_r   <= drsp.quo[IMPR_W-1:0];
            state_r <= S_DIST;
          end
        end
        S_DIST: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            dist_r      <= (dist_full > (LAP_BITS+POOL_W)'(24'hFFFFFF)) ? '1
                           : DIST_W'(dist_full);
            out_valid_r <= 1'b1;
          end else if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_lap_done, out_lap_total,
      out_distance_m, out_score_average, out_improvement_pct}));
  // While a result waits, neither input nor configuration is taken.
  a_out_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall && !cfg_ready);
  // An accepted sample beat makes the block busy on the next cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall);
`endif
endmodule
